@@ design/button_press_classifier_core_defines.svh @@
//------------------------------------------------------------------------------
// button press classifier assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
//------------------------------------------------------------------------------
`ifndef BUTTON_PRESS_CLASSIFIER_CORE_DEFINES_SVH
`define BUTTON_PRESS_CLASSIFIER_CORE_DEFINES_SVH

`ifndef SYNTH
// checked only outside reset
`define BPC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("bpc assertion failed");
// checked at every edge, reset included
`define BPC_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("bpc assertion failed");
`else
`define BPC_ASSERT(lbl, clk, rst_n, prop)
`define BPC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ design/bpc_pkg.sv @@
//------------------------------------------------------------------------------
// bpc_pkg
// shared codes, widths and types of the button press classifier
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpc_pkg;

	localparam int TICK_W  = 10;
	localparam int PRESS_W = 8;
	localparam int PHASE_W = 2;
	localparam int EVENT_W = 3;
	localparam int CFG_IDX_W = 2;

	// phase codes
	localparam logic [PHASE_W-1:0] PH_IDLE     = 2'd0;
	localparam logic [PHASE_W-1:0] PH_PRESSED  = 2'd1;
	localparam logic [PHASE_W-1:0] PH_RELEASED = 2'd2;

	// event codes
	localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
	localparam logic [EVENT_W-1:0] EV_SHORT   = 3'd1;
	localparam logic [EVENT_W-1:0] EV_LONG    = 3'd2;
	localparam logic [EVENT_W-1:0] EV_TIMEOUT = 3'd3;
	localparam logic [EVENT_W-1:0] EV_GLITCH  = 3'd4;

	// operation codes
	localparam logic OP_PIN  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_HOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd2;

	localparam logic [TICK_W-1:0] SHORT_HOLD_RST = 10'd40;
	localparam logic [TICK_W-1:0] LONG_HOLD_RST  = 10'd80;
	localparam logic [TICK_W-1:0] TIMEOUT_RST    = 10'd197;

	localparam logic [TICK_W-1:0]  TICK_MAX  = '1;
	localparam logic [PRESS_W-1:0] PRESS_MAX = '1;

	typedef struct packed {
		logic [TICK_W-1:0] short_hold;
		logic [TICK_W-1:0] long_hold;
		logic [TICK_W-1:0] timeout;
	} bpc_cfg_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [TICK_W-1:0]  elapsed;
		logic [PRESS_W-1:0] quick_presses;
		logic               counting;
	} bpc_state_t;

	typedef struct packed {
		logic [EVENT_W-1:0] event_kind;
		logic [PRESS_W-1:0] press_count;
	} bpc_result_t;

endpackage

@@ design/bpc_cfg_regs.sv @@
//------------------------------------------------------------------------------
// bpc_cfg_regs
// hold and timeout threshold registers with indexed write port
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpc_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bpc_pkg::TICK_W-1:0]   cfg_data,
	output bpc_pkg::bpc_cfg_t            cfg
);
	import bpc_pkg::*;

	bpc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_hold <= SHORT_HOLD_RST;
			cfg_q.long_hold  <= LONG_HOLD_RST;
			cfg_q.timeout    <= TIMEOUT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SHORT_HOLD: cfg_q.short_hold <= cfg_data;
				CFG_LONG_HOLD:  cfg_q.long_hold  <= cfg_data;
				CFG_TIMEOUT:    cfg_q.timeout    <= cfg_data;
				default: begin
					// index beyond the register list: dropped
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/bpc_step.sv @@
//------------------------------------------------------------------------------
// bpc_step
// next-state and event logic for one pin change or tick word
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpc_step (
	input  bpc_pkg::bpc_cfg_t    cfg,
	input  bpc_pkg::bpc_state_t  cur,
	input  logic                 operation,
	input  logic                 pin_level,
	output bpc_pkg::bpc_state_t  nxt,
	output bpc_pkg::bpc_result_t res
);
	import bpc_pkg::*;

	logic first_hold;

	assign first_hold = (cur.quick_presses == '0);

	always_comb begin
		nxt = cur;
		res.event_kind = EV_NONE;
		if (operation == OP_PIN) begin
			// any pin change stops the timer, continuing paths restart it
			nxt.counting = 1'b0;
			case (cur.phase)
				PH_IDLE: begin
					if (pin_level) begin
						nxt.counting = 1'b1;
						nxt.phase    = PH_PRESSED;
					end
				end
				PH_PRESSED: begin
					if (pin_level) begin
						nxt.phase         = PH_IDLE;
						nxt.quick_presses = '0;
						nxt.elapsed       = '0;
						res.event_kind    = EV_GLITCH;
					end else if (first_hold && cur.elapsed >= cfg.long_hold) begin
						nxt.phase         = PH_IDLE;
						nxt.quick_presses = '0;
						nxt.elapsed       = '0;
						res.event_kind    = EV_LONG;
					end else if (first_hold && cur.elapsed >= cfg.short_hold) begin
						nxt.phase         = PH_IDLE;
						nxt.quick_presses = '0;
						nxt.elapsed       = '0;
						res.event_kind    = EV_SHORT;
					end else begin
						nxt.phase    = PH_RELEASED;
						nxt.counting = 1'b1;
						if (cur.quick_presses != PRESS_MAX)
							nxt.quick_presses = cur.quick_presses + PRESS_W'(1);
					end
				end
				PH_RELEASED: begin
					if (pin_level) begin
						nxt.counting = 1'b1;
						nxt.phase    = PH_PRESSED;
					end else begin
						nxt.phase         = PH_IDLE;
						nxt.quick_presses = '0;
						nxt.elapsed       = '0;
						res.event_kind    = EV_GLITCH;
					end
				end
				default: begin
					nxt.phase         = PH_IDLE;
					nxt.quick_presses = '0;
					nxt.elapsed       = '0;
					res.event_kind    = EV_GLITCH;
				end
			endcase
			res.press_count = nxt.quick_presses;
		end else begin
			// timeout reports the count before it is cleared
			res.press_count = cur.quick_presses;
			if (cur.counting) begin
				if (cur.elapsed > cfg.timeout) begin
					nxt.counting      = 1'b0;
					nxt.phase         = PH_IDLE;
					nxt.quick_presses = '0;
					nxt.elapsed       = '0;
					res.event_kind    = EV_TIMEOUT;
				end else if (cur.elapsed != TICK_MAX) begin
					nxt.elapsed = cur.elapsed + TICK_W'(1);
				end
			end
		end
	end

endmodule

@@ design/bpc_out_buf.sv @@
//------------------------------------------------------------------------------
// bpc_out_buf
// two-word result buffer between the step logic and the result channel
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpc_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  bpc_pkg::bpc_result_t push_data,
	output logic                 full,
	output logic                 result_valid,
	input  logic                 result_stall,
	output bpc_pkg::bpc_result_t head
);
	import bpc_pkg::*;

	`include "button_press_classifier_core_defines.svh"

	bpc_result_t slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        pop;

	assign full         = (count_q == 2'd2);
	assign result_valid = (count_q != 2'd0);
	assign pop          = result_valid && !result_stall;
	assign head         = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	`BPC_ASSERT_ALWAYS(a_count_bound, clk, !arst_n || count_q != 2'd3)
	`BPC_ASSERT(a_no_push_full, clk, arst_n, full |-> !push)
	`BPC_ASSERT(a_ptr_gap, clk, arst_n, (!result_valid || full) |-> (wr_ptr_q == rd_ptr_q))

endmodule

@@ design/button_press_classifier_core.sv @@
//------------------------------------------------------------------------------
// button_press_classifier_core
// hold, quick press, timeout and glitch classifier for one debounced button
//------------------------------------------------------------------------------
// item channel (item_valid / item_stall): one word per pin change or timer
//   tick; operation 0 is a pin change carrying pin_level, 1 is a tick.
// result channel (result_valid / result_stall): exactly one word per item,
//   event_kind and press_count, in item order.
// cfg channel (cfg_valid / cfg_ready): writes short hold, long hold and
//   timeout thresholds by index; always ready. thresholds are written while
//   the block idles, a rule for the user that the block does not enforce.
// an accepted item waits in the input register; the step logic updates phase,
//   tick count and press count and pushes the result word into a two-word
//   output buffer, raising result_valid. one item per cycle if it is not full.
// when the receiver stalls the buffer fills; once full and an item waits in
//   the input register, item_stall rises until a result word is taken.
// reset empties the buffer and input register, returns the phase to idle with
//   zero counts and the timer stopped, and loads thresholds 40, 80 and 197.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_press_classifier_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic                          operation,
	input  logic                          pin_level,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [bpc_pkg::EVENT_W-1:0]   event_kind,
	output logic [bpc_pkg::PRESS_W-1:0]   press_count,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bpc_pkg::TICK_W-1:0]    cfg_data
);
	import bpc_pkg::*;

	`include "button_press_classifier_core_defines.svh"

	bpc_cfg_t    cfg;
	bpc_state_t  state_q;
	bpc_state_t  state_nxt;
	bpc_result_t res;
	bpc_result_t head;
	logic        valid_s1;
	logic        op_s1;
	logic        pin_s1;
	logic        buf_full;
	logic        fire;
	logic        take;

	assign cfg_ready  = 1'b1;
	assign fire       = valid_s1 && !buf_full;
	assign item_stall = valid_s1 && buf_full;
	assign take       = item_valid && !item_stall;

	bpc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (take)
			valid_s1 <= 1'b1;
		else if (fire)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1  <= operation;
			pin_s1 <= pin_level;
		end
	end

	bpc_step u_step (
		.cfg       (cfg),
		.cur       (state_q),
		.operation (op_s1),
		.pin_level (pin_s1),
		.nxt       (state_nxt),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase         <= PH_IDLE;
			state_q.elapsed       <= '0;
			state_q.quick_presses <= '0;
			state_q.counting      <= 1'b0;
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

	bpc_out_buf u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (fire),
		.push_data    (res),
		.full         (buf_full),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.head         (head)
	);

	assign event_kind  = head.event_kind;
	assign press_count = head.press_count;

	`BPC_ASSERT(a_stall_holds_word, clk, arst_n, item_stall |-> valid_s1)
	`BPC_ASSERT(a_event_ends_seq, clk, arst_n, (fire && res.event_kind != EV_NONE) |=> (state_q.phase == PH_IDLE && state_q.quick_presses == '0 && state_q.elapsed == '0))
	`BPC_ASSERT(a_timer_in_seq, clk, arst_n, state_q.counting |-> (state_q.phase != PH_IDLE))

endmodule
